FILE: sv/ssvs_pkg.sv
package ssvs_pkg;

   localparam int VOLUME_STEPS   = 100;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int DB_TABLE_LEN   = 100;

   localparam int SAMPLE_W  = 32;
   localparam int VOL_W     = 7;
   localparam int RG_W      = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = RG_W;

   localparam int TBL_IDX_W = $clog2(DB_TABLE_LEN);
   localparam int BASE_W    = GAIN_FRAC_BITS + 1;
   localparam int GAIN_W    = BASE_W + RG_W - 16;
   localparam int MAG_W     = SAMPLE_W;
   localparam int PROD_W    = MAG_W + GAIN_W;
   localparam int Q_W       = PROD_W + 1 - GAIN_FRAC_BITS;
   localparam int GAIN_UP   = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
   localparam int GAIN_DN   = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;

   localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(VOLUME_STEPS);
   localparam logic [RG_W-1:0]  RG_RESET  = RG_W'(65536);

   typedef enum logic [1:0] {
      MODE_16   = 2'd0,
      MODE_24   = 2'd1,
      MODE_32   = 2'd2,
      MODE_PASS = 2'd3
   } sample_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_MODE = 3'd0,
      CSR_BYTE_SWAP   = 3'd1,
      CSR_VOL_EN      = 3'd2,
      CSR_VOL_LEFT    = 3'd3,
      CSR_VOL_RIGHT   = 3'd4,
      CSR_RG_SCALE    = 3'd5
   } csr_reg_type;

   typedef struct packed {
      sample_mode_type       mode;
      logic                  swap;
      logic                  vol_en;
      logic [RG_W-1:0]       rg_scale;
   } lane_cfg_type;

   // load enables for the two lane pipeline stages
   typedef struct packed {
      logic a;
      logic b;
   } stage_en_type;

   localparam logic [15:0] DB_GAIN_Q16 [DB_TABLE_LEN] = '{
      16'h0000, 16'h0110, 16'h011c, 16'h012f, 16'h013d, 16'h0152, 16'h0161, 16'h0179,
      16'h018a, 16'h01a5, 16'h01c1, 16'h01d5, 16'h01f5, 16'h020b, 16'h022e, 16'h0247,
      16'h026e, 16'h028a, 16'h02b6, 16'h02d5, 16'h0306, 16'h033a, 16'h035f, 16'h0399,
      16'h03c2, 16'h0403, 16'h0431, 16'h0479, 16'h04ac, 16'h04fd, 16'h0553, 16'h058f,
      16'h05ef, 16'h0633, 16'h069e, 16'h06ea, 16'h0761, 16'h07b5, 16'h083a, 16'h0898,
      16'h092c, 16'h09cb, 16'h0a3a, 16'h0aeb, 16'h0b67, 16'h0c2c, 16'h0cb6, 16'h0d92,
      16'h0e2d, 16'h0f21, 16'h1027, 16'h10de, 16'h1202, 16'h12cf, 16'h1414, 16'h14f8,
      16'h1662, 16'h1761, 16'h18f5, 16'h1a11, 16'h1bd3, 16'h1db4, 16'h1f06, 16'h211d,
      16'h2297, 16'h24ec, 16'h2690, 16'h292a, 16'h2aff, 16'h2de5, 16'h30fe, 16'h332b,
      16'h369f, 16'h390d, 16'h3ce6, 16'h3f9b, 16'h43e6, 16'h46eb, 16'h4bb3, 16'h4f11,
      16'h5466, 16'h5a18, 16'h5e19, 16'h6472, 16'h68ea, 16'h6ffd, 16'h74f8, 16'h7cdc,
      16'h826a, 16'h8b35, 16'h9499, 16'h9b35, 16'ha5ad, 16'had0b, 16'hb8b7, 16'hc0ee,
      16'hcdf1, 16'hd71a, 16'he59c, 16'hefd3
   };

   function automatic logic [15:0] swap16(input logic [15:0] x);
      swap16 = {x[7:0], x[15:8]};
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] x);
      swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

FILE: sv/ssvs_ifs.sv
interface ssvs_req_if;
   import ssvs_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] left_in;
   logic [SAMPLE_W-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface ssvs_rsp_if;
   import ssvs_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] left_out;
   logic [SAMPLE_W-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

FILE: sv/stereo_soft_volume_scaler_top.sv
// Channel   Dir  Handshake        Payload
// req_ch    in   valid / ready    left_in[31:0], right_in[31:0]
// rsp_ch    out  valid / ready    left_out[31:0], right_out[31:0]
// csr_*     in   csr_we           csr_index[2:0], csr_wdata[20:0]
//
// One frame per cycle while the output is not stalled; a frame passes stage A
// (gain and magnitude), stage B (sample multiply) and the output register
// (round/clamp), from which it can leave. Up to three frames in flight.
// Both channels run in their own lane; the output register merges them.
// Synchronous active-high reset clears the stage valids and loads the
// register defaults. Stages hold under output stall; bubbles still collapse.
module stereo_soft_volume_scaler_top
   import ssvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ssvs_req_if.sink              req_ch,
   ssvs_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   sample_mode_type    mode_ff;
   logic               swap_ff;
   logic               vol_en_ff;
   logic [VOL_W-1:0]   vol_left_ff;
   logic [VOL_W-1:0]   vol_right_ff;
   logic [RG_W-1:0]    rg_scale_ff;

   lane_cfg_type       cfg;
   stage_en_type       en;

   logic               v_a_ff;
   logic               v_b_ff;
   logic               out_valid_ff;
   logic               rdy_out;
   logic               rdy_b;
   logic               rdy_a;

   logic [SAMPLE_W-1:0] left_res;
   logic [SAMPLE_W-1:0] right_res;
   logic [SAMPLE_W-1:0] left_out_ff;
   logic [SAMPLE_W-1:0] right_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_16;
         swap_ff      <= 1'b0;
         vol_en_ff    <= 1'b0;
         vol_left_ff  <= VOL_RESET;
         vol_right_ff <= VOL_RESET;
         rg_scale_ff  <= RG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_MODE: mode_ff      <= sample_mode_type'(csr_wdata[1:0]);
            CSR_BYTE_SWAP:   swap_ff      <= csr_wdata[0];
            CSR_VOL_EN:      vol_en_ff    <= csr_wdata[0];
            CSR_VOL_LEFT:    vol_left_ff  <= csr_wdata[VOL_W-1:0];
            CSR_VOL_RIGHT:   vol_right_ff <= csr_wdata[VOL_W-1:0];
            CSR_RG_SCALE:    rg_scale_ff  <= csr_wdata[RG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.mode     = mode_ff;
      cfg.swap     = swap_ff;
      cfg.vol_en   = vol_en_ff;
      cfg.rg_scale = rg_scale_ff;

      rdy_out = !out_valid_ff || rsp_ch.ready;
      rdy_b   = !v_b_ff || rdy_out;
      rdy_a   = !v_a_ff || rdy_b;
      en.a    = rdy_a;
      en.b    = rdy_b;
   end

   assign req_ch.ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff       <= 1'b0;
         v_b_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            v_a_ff <= req_ch.valid;
         end
         if (rdy_b) begin
            v_b_ff <= v_a_ff;
         end
         if (rdy_out) begin
            out_valid_ff <= v_b_ff;
         end
      end
   end

   ssvs_lane u_lane_left (
      .clock   (clock),
      .en      (en),
      .cfg     (cfg),
      .vol_idx (vol_left_ff),
      .raw_in  (req_ch.left_in),
      .result  (left_res)
   );

   ssvs_lane u_lane_right (
      .clock   (clock),
      .en      (en),
      .cfg     (cfg),
      .vol_idx (vol_right_ff),
      .raw_in  (req_ch.right_in),
      .result  (right_res)
   );

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         left_out_ff  <= left_res;
         right_out_ff <= right_res;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.left_out  = left_out_ff;
   assign rsp_ch.right_out = right_out_ff;

endmodule

FILE: sv/ssvs_gain.sv
module ssvs_gain
   import ssvs_pkg::*;
(
   input  logic              vol_en,
   input  logic [VOL_W-1:0]  vol_idx,
   input  logic [RG_W-1:0]   rg_scale,
   output logic [GAIN_W-1:0] gain
);

   logic [TBL_IDX_W-1:0]     tbl_idx;
   logic [31:0]              tbl_conv;
   logic [BASE_W-1:0]        base;
   logic [BASE_W+RG_W-1:0]   prod;

   always_comb begin
      // indexes past the table use its last entry
      if (32'(vol_idx) < DB_TABLE_LEN) begin
         tbl_idx = TBL_IDX_W'(vol_idx);
      end else begin
         tbl_idx = TBL_IDX_W'(DB_TABLE_LEN - 1);
      end
      tbl_conv = ({16'b0, DB_GAIN_Q16[tbl_idx]} << GAIN_UP) >> GAIN_DN;
      if (vol_en && (32'(vol_idx) < VOLUME_STEPS)) begin
         base = tbl_conv[BASE_W-1:0];
      end else begin
         base = BASE_W'(1) << GAIN_FRAC_BITS;
      end
      prod = BASE_W'(base) * RG_W'(rg_scale);
      gain = prod[BASE_W+RG_W-1:16];
   end

endmodule

FILE: sv/ssvs_lane.sv
module ssvs_lane
   import ssvs_pkg::*;
(
   input  logic                clock,
   input  stage_en_type        en,
   input  lane_cfg_type        cfg,
   input  logic [VOL_W-1:0]    vol_idx,
   input  logic [SAMPLE_W-1:0] raw_in,
   output logic [SAMPLE_W-1:0] result
);

   logic [GAIN_W-1:0]   gain;

   logic [SAMPLE_W:0]   sx;
   logic [SAMPLE_W:0]   sx_neg;
   logic [MAG_W-1:0]    mag_in;
   logic                neg_in;

   logic [SAMPLE_W-1:0] raw_a_ff;
   logic [MAG_W-1:0]    mag_a_ff;
   logic                neg_a_ff;
   logic [GAIN_W-1:0]   gain_a_ff;
   sample_mode_type     mode_a_ff;
   logic                swap_a_ff;

   logic [SAMPLE_W-1:0] raw_b_ff;
   logic [PROD_W-1:0]   prod_b_ff;
   logic                neg_b_ff;
   sample_mode_type     mode_b_ff;
   logic                swap_b_ff;

   logic [Q_W-1:0]      q;
   logic [SAMPLE_W-1:0] top_val;
   logic [SAMPLE_W-1:0] lim;
   logic [SAMPLE_W-1:0] q_sat;
   logic [SAMPLE_W-1:0] signed_res;

   ssvs_gain u_gain (
      .vol_en   (cfg.vol_en),
      .vol_idx  (vol_idx),
      .rg_scale (cfg.rg_scale),
      .gain     (gain)
   );

   // stage A input: sign-extend the sample and take its magnitude
   always_comb begin
      unique case (cfg.mode)
         MODE_16: begin
            if (cfg.swap) begin
               sx = {{17{raw_in[7]}}, swap16(raw_in[15:0])};
            end else begin
               sx = {{17{raw_in[15]}}, raw_in[15:0]};
            end
         end
         MODE_24: begin
            sx = {{9{raw_in[23]}}, raw_in[23:0]};
         end
         MODE_32: begin
            if (cfg.swap) begin
               sx = {raw_in[7], swap32(raw_in)};
            end else begin
               sx = {raw_in[31], raw_in};
            end
         end
         default: begin
            sx = '0;
         end
      endcase
      sx_neg = ~sx + 1'b1;
      neg_in = sx[SAMPLE_W];
      mag_in = neg_in ? sx_neg[MAG_W-1:0] : sx[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.a) begin
         raw_a_ff  <= raw_in;
         mag_a_ff  <= mag_in;
         neg_a_ff  <= neg_in;
         gain_a_ff <= gain;
         mode_a_ff <= cfg.mode;
         swap_a_ff <= cfg.swap;
      end
   end

   always_ff @(posedge clock) begin
      if (en.b) begin
         raw_b_ff  <= raw_a_ff;
         prod_b_ff <= PROD_W'(mag_a_ff) * PROD_W'(gain_a_ff);
         neg_b_ff  <= neg_a_ff;
         mode_b_ff <= mode_a_ff;
         swap_b_ff <= swap_a_ff;
      end
   end

   // round half away from zero on the magnitude, clamp, restore sign
   always_comb begin
      q = Q_W'((PROD_W + 1)'(prod_b_ff) + ((PROD_W + 1)'(1) << (GAIN_FRAC_BITS - 1))
               >> GAIN_FRAC_BITS);
      unique case (mode_b_ff)
         MODE_16: top_val = 32'h0000_8000;
         MODE_24: top_val = 32'h0080_0000;
         default: top_val = 32'h8000_0000;
      endcase
      lim = neg_b_ff ? top_val : top_val - 1'b1;
      if (q > Q_W'(lim)) begin
         q_sat = lim;
      end else begin
         q_sat = q[SAMPLE_W-1:0];
      end
      signed_res = neg_b_ff ? (~q_sat + 1'b1) : q_sat;

      unique case (mode_b_ff)
         MODE_16: begin
            if (swap_b_ff) begin
               result = {16'b0, swap16(signed_res[15:0])};
            end else begin
               result = {16'b0, signed_res[15:0]};
            end
         end
         MODE_24: begin
            // swapped 24-bit audio is not handled; its low 24 input bits go out unscaled
            if (swap_b_ff) begin
               result = {8'b0, raw_b_ff[23:0]};
            end else begin
               result = {8'b0, signed_res[23:0]};
            end
         end
         MODE_32: begin
            result = swap_b_ff ? swap32(signed_res) : signed_res;
         end
         default: begin
            result = raw_b_ff;
         end
      endcase
   end

endmodule

FILE: sim/stereo_soft_volume_scaler_top_tb.sv
`timescale 1ns / 100ps

module stereo_soft_volume_scaler_top_tb;
   import ssvs_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int N_PHASES      = 16;
   localparam int PHASE_FRAMES  = 100;
   localparam int N_ROWS        = 21;
   localparam int DRAIN_CYCLES  = 10;
   localparam int IDLE_PCT      = 7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } stereo_frame_type;

   // one directed vector: settings, input frame, and a typed expectation if known
   typedef struct packed {
      sample_mode_type     mode;
      logic                swap;
      logic                vol_en;
      logic [VOL_W-1:0]    vol_l;
      logic [VOL_W-1:0]    vol_r;
      logic [RG_W-1:0]     rg;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                typed;
      logic [SAMPLE_W-1:0] want_l;
      logic [SAMPLE_W-1:0] want_r;
   } vector_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ssvs_req_if req_ch();
   ssvs_rsp_if rsp_ch();

   stereo_soft_volume_scaler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers
   sample_mode_type  cfg_mode;
   logic             cfg_swap;
   logic             cfg_vol_en;
   logic [VOL_W-1:0] cfg_vol_l;
   logic [VOL_W-1:0] cfg_vol_r;
   logic [RG_W-1:0]  cfg_rg;

   stereo_frame_type frames_due[$];
   stereo_frame_type due_frame;
   vector_row_type   directed_rows [N_ROWS];
   int               mismatches;
   int               cycles;
   logic             no_idle;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [63:0] lane_gain(input logic [VOL_W-1:0] idx);
      logic [63:0] base;
      int          t;
      base = 64'd1 << GAIN_FRAC_BITS;
      if (cfg_vol_en && int'(idx) < VOLUME_STEPS) begin
         t = (int'(idx) < DB_TABLE_LEN) ? int'(idx) : DB_TABLE_LEN - 1;
         base = ({48'd0, DB_GAIN_Q16[t]} << GAIN_UP) >> GAIN_DN;
      end
      return (base * {43'd0, cfg_rg}) >> 16;
   endfunction

   // sign-magnitude multiply, round half away from zero, clamp to the width
   function automatic logic [31:0] scale_sample(input logic [31:0] raw, input int bits,
                                                input logic [63:0] gain);
      logic [63:0] full, top, v, mag, q;
      logic        neg;
      full = 64'd1 << bits;
      top  = 64'd1 << (bits - 1);
      v    = {32'd0, raw} & (full - 1);
      neg  = (v & top) != 0;
      mag  = neg ? full - v : v;
      q    = (mag * gain + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
      if (neg) begin
         if (q > top) q = top;
         return 32'((full - q) & (full - 1));
      end
      if (q > top - 1) q = top - 1;
      return 32'(q);
   endfunction

   function automatic logic [31:0] scale_lane(input logic [31:0] raw, input logic [63:0] gain);
      logic [31:0] w, s;
      case (cfg_mode)
         MODE_16: begin
            if (cfg_swap) begin
               s = scale_sample({16'd0, raw[7:0], raw[15:8]}, 16, gain);
               return {16'd0, s[7:0], s[15:8]};
            end
            return scale_sample({16'd0, raw[15:0]}, 16, gain);
         end
         MODE_24: begin
            if (cfg_swap) return {8'd0, raw[23:0]};
            return scale_sample({8'd0, raw[23:0]}, 24, gain);
         end
         MODE_32: begin
            if (cfg_swap) begin
               w = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
               s = scale_sample(w, 32, gain);
               return {s[7:0], s[15:8], s[23:16], s[31:24]};
            end
            return scale_sample(raw, 32, gain);
         end
         default: return raw;
      endcase
   endfunction

   function automatic stereo_frame_type predict_frame(input logic [31:0] l,
                                                      input logic [31:0] r);
      stereo_frame_type f;
      f.left  = scale_lane(l, lane_gain(cfg_vol_l));
      f.right = scale_lane(r, lane_gain(cfg_vol_r));
      return f;
   endfunction

   function automatic logic [31:0] rand_sample();
      logic [31:0] pick;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 8))
               0: pick = 32'h0000_7fff;
               1: pick = 32'h0000_8000;
               2: pick = 32'h007f_ffff;
               3: pick = 32'h0080_0000;
               4: pick = 32'h7fff_ffff;
               5: pick = 32'h8000_0000;
               6: pick = 32'hffff_ffff;
               7: pick = 32'h0000_0001;
               default: pick = 32'h0000_0000;
            endcase
         end
         1: pick = $urandom_range(0, 255);
         2: pick = -$urandom_range(1, 256);
         default: pick = $urandom();
      endcase
      return pick;
   endfunction

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SAMPLE_MODE: cfg_mode   = sample_mode_type'(val[1:0]);
         CSR_BYTE_SWAP:   cfg_swap   = val[0];
         CSR_VOL_EN:      cfg_vol_en = val[0];
         CSR_VOL_LEFT:    cfg_vol_l  = val[VOL_W-1:0];
         CSR_VOL_RIGHT:   cfg_vol_r  = val[VOL_W-1:0];
         CSR_RG_SCALE:    cfg_rg     = val[RG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // holds the sender off until the pipe is empty, then reprograms every register
   task automatic load_settings(input sample_mode_type mode, input logic swap,
                                input logic vol_en,
                                input logic [VOL_W-1:0] vl, input logic [VOL_W-1:0] vr,
                                input logic [RG_W-1:0] rg);
      req_ch.valid <= 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      write_reg(CSR_SAMPLE_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_BYTE_SWAP,   CSR_DATA_W'(swap));
      write_reg(CSR_VOL_EN,      CSR_DATA_W'(vol_en));
      write_reg(CSR_VOL_LEFT,    CSR_DATA_W'(vl));
      write_reg(CSR_VOL_RIGHT,   CSR_DATA_W'(vr));
      write_reg(CSR_RG_SCALE,    CSR_DATA_W'(rg));
      csr_we <= 1'b0;
   endtask

   // entered and left at a falling edge; valid stays high after the transfer
   task automatic send_frame(input logic [31:0] l, input logic [31:0] r,
                             input stereo_frame_type want);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.left_in  <= l;
      req_ch.right_in <= r;
      do @(posedge clock); while (!req_ch.ready);
      frames_due.push_back(want);
      @(negedge clock);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (frames_due.size() == 0) begin
            $display("%0t unexpected transfer: left_out %h right_out %h", $time,
                     rsp_ch.left_out, rsp_ch.right_out);
            mismatches++;
         end else begin
            due_frame = frames_due.pop_front();
            if (rsp_ch.left_out !== due_frame.left) begin
               $display("%0t left_out expected %h actual %h", $time,
                        due_frame.left, rsp_ch.left_out);
               mismatches++;
            end
            if (rsp_ch.right_out !== due_frame.right) begin
               $display("%0t right_out expected %h actual %h", $time,
                        due_frame.right, rsp_ch.right_out);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t timeout, %0d transfers outstanding", $time, frames_due.size());
         $display("** stereo_soft_volume_scaler_top: FAILED **");
         $finish;
      end
   end

   initial begin
      sample_mode_type  mode;
      logic [VOL_W-1:0] vl, vr;
      logic [RG_W-1:0]  rg;
      logic [31:0]      l, r;
      stereo_frame_type want;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.left_in  = '0;
      req_ch.right_in = '0;
      mismatches      = 0;
      cycles          = 0;
      no_idle         = 1'b0;
      cfg_mode        = MODE_16;
      cfg_swap        = 1'b0;
      cfg_vol_en      = 1'b0;
      cfg_vol_l       = VOL_RESET;
      cfg_vol_r       = VOL_RESET;
      cfg_rg          = RG_RESET;

      // the first two rows run on the register defaults
      directed_rows = '{
         '{MODE_16,   1'b0, 1'b0, 7'd100, 7'd100, 21'd65536,
           32'h1234_5678, 32'hffff_8000, 1'b1, 32'h0000_5678, 32'h0000_8000},
         '{MODE_16,   1'b0, 1'b0, 7'd100, 7'd100, 21'd65536,
           32'h0000_7fff, 32'habcd_0001, 1'b1, 32'h0000_7fff, 32'h0000_0001},
         '{MODE_16,   1'b0, 1'b1, 7'd0,   7'd0,   21'd65536,
           32'h0000_7fff, 32'h0000_8000, 1'b1, 32'h0000_0000, 32'h0000_0000},
         '{MODE_16,   1'b0, 1'b1, 7'd1,   7'd99,  21'd65536,
           32'h0000_7fff, 32'h0000_8000, 1'b0, 32'h0, 32'h0},
         '{MODE_16,   1'b0, 1'b1, 7'd1,   7'd99,  21'd65536,
           32'hffff_ffff, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
         '{MODE_16,   1'b1, 1'b0, 7'd100, 7'd100, 21'd1310720,
           32'h0000_0080, 32'h0000_ff7f, 1'b0, 32'h0, 32'h0},
         '{MODE_16,   1'b0, 1'b0, 7'd100, 7'd100, 21'd32768,
           32'h0000_0003, 32'h0000_fffd, 1'b0, 32'h0, 32'h0},
         '{MODE_16,   1'b0, 1'b0, 7'd100, 7'd100, 21'd32768,
           32'h0000_0001, 32'h0000_ffff, 1'b0, 32'h0, 32'h0},
         '{MODE_24,   1'b0, 1'b0, 7'd100, 7'd100, 21'd65536,
           32'hff7f_ffff, 32'h0080_0000, 1'b1, 32'h007f_ffff, 32'h0080_0000},
         '{MODE_24,   1'b0, 1'b1, 7'd50,  7'd127, 21'd1310720,
           32'h007f_ffff, 32'h0080_0000, 1'b0, 32'h0, 32'h0},
         '{MODE_24,   1'b0, 1'b1, 7'd100, 7'd64,  21'd1310720,
           32'h0000_0001, 32'h00ff_ffff, 1'b0, 32'h0, 32'h0},
         '{MODE_24,   1'b1, 1'b1, 7'd10,  7'd10,  21'd1310720,
           32'hdead_beef, 32'h0123_4567, 1'b1, 32'h00ad_beef, 32'h0023_4567},
         '{MODE_32,   1'b0, 1'b0, 7'd100, 7'd100, 21'd0,
           32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
         '{MODE_32,   1'b0, 1'b0, 7'd100, 7'd100, 21'd131072,
           32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h7fff_ffff, 32'h8000_0000},
         '{MODE_32,   1'b0, 1'b0, 7'd100, 7'd100, 21'd131072,
           32'h0000_0001, 32'hffff_ffff, 1'b0, 32'h0, 32'h0},
         '{MODE_32,   1'b1, 1'b1, 7'd99,  7'd0,   21'd1310720,
           32'h0000_00c0, 32'h1234_5678, 1'b0, 32'h0, 32'h0},
         '{MODE_32,   1'b1, 1'b0, 7'd100, 7'd100, 21'd65536,
           32'h7856_3412, 32'h0000_0080, 1'b0, 32'h0, 32'h0},
         '{MODE_32,   1'b0, 1'b1, 7'd127, 7'd101, 21'd98304,
           32'h4000_0000, 32'hc000_0000, 1'b0, 32'h0, 32'h0},
         '{MODE_PASS, 1'b1, 1'b1, 7'd0,   7'd0,   21'd0,
           32'hdead_beef, 32'h0123_4567, 1'b1, 32'hdead_beef, 32'h0123_4567},
         '{MODE_PASS, 1'b0, 1'b0, 7'd100, 7'd100, 21'd65536,
           32'hffff_ffff, 32'h0000_0000, 1'b1, 32'hffff_ffff, 32'h0000_0000},
         '{MODE_16,   1'b0, 1'b1, 7'd99,  7'd98,  21'd1310720,
           32'h0000_8000, 32'h0000_7fff, 1'b0, 32'h0, 32'h0}
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != cfg_mode || directed_rows[i].swap != cfg_swap ||
             directed_rows[i].vol_en != cfg_vol_en || directed_rows[i].vol_l != cfg_vol_l ||
             directed_rows[i].vol_r != cfg_vol_r || directed_rows[i].rg != cfg_rg)
            load_settings(directed_rows[i].mode, directed_rows[i].swap,
                          directed_rows[i].vol_en, directed_rows[i].vol_l,
                          directed_rows[i].vol_r, directed_rows[i].rg);
         if (directed_rows[i].typed)
            want = '{directed_rows[i].want_l, directed_rows[i].want_r};
         else
            want = predict_frame(directed_rows[i].left, directed_rows[i].right);
         send_frame(directed_rows[i].left, directed_rows[i].right, want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: mode = MODE_16;
            3, 4, 5: mode = MODE_24;
            6, 7, 8: mode = MODE_32;
            default: mode = MODE_PASS;
         endcase
         vl = ($urandom_range(0, 9) == 0) ? VOL_W'($urandom_range(100, 127))
                                          : VOL_W'($urandom_range(0, 99));
         vr = ($urandom_range(0, 9) == 0) ? VOL_W'($urandom_range(100, 127))
                                          : VOL_W'($urandom_range(0, 99));
         case ($urandom_range(0, 7))
            0: rg = 21'd0;
            1: rg = 21'd1310720;
            2: rg = 21'd65536;
            7: rg = RG_W'($urandom_range(0, 1310720));
            default: rg = RG_W'($urandom_range(0, 131072));
         endcase
         load_settings(mode, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, vl, vr, rg);
         no_idle = (p >= 4 && p <= 6);
         repeat (PHASE_FRAMES) begin
            l = rand_sample();
            r = rand_sample();
            send_frame(l, r, predict_frame(l, r));
         end
      end
      no_idle = 1'b0;

      req_ch.valid <= 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** stereo_soft_volume_scaler_top: PASSED **");
      else
         $display("** stereo_soft_volume_scaler_top: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
sv/ssvs_pkg.sv
sv/ssvs_ifs.sv
sv/ssvs_gain.sv
sv/ssvs_lane.sv
sv/stereo_soft_volume_scaler_top.sv
sim/stereo_soft_volume_scaler_top_tb.sv
